// File: src/dhte_pkg.sv
`default_nettype none
package dhte_pkg;

	// default sizing
	localparam int CAPACITY_DEF   = 1024;
	localparam int VALUE_BITS_DEF = 32;

	// field widths
	localparam int KEY_W   = 31;
	localparam int VAL_W   = 32;
	localparam int TSIZE_W = 11;
	localparam int DIV_W   = 16;
	localparam int SLOT_W  = 10;
	localparam int CNT_W   = 11;
	localparam int SUM_W   = 48;

	// register reset values
	localparam logic [TSIZE_W-1:0] TSIZE_RESET = 11'd1024;
	localparam logic [DIV_W-1:0]   DIV_RESET   = 16'd7;
	localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};

	// configuration register indexes
	localparam logic CFG_TABLE_SIZE   = 1'b0;
	localparam logic CFG_STEP_DIVISOR = 1'b1;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_ERASE  = 2'd1;
	localparam logic [1:0] OP_FIND   = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	// slot states
	localparam logic [1:0] SLOT_EMPTY = 2'd0;
	localparam logic [1:0] SLOT_OCC   = 2'd1;
	localparam logic [1:0] SLOT_TOMB  = 2'd2;

	typedef struct packed {
		logic [1:0]       op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic              status;
		logic [SLOT_W-1:0] home_slot;
		logic [SLOT_W-1:0] stored_slot;
		logic [VAL_W-1:0]  found_value;
		logic [CNT_W-1:0]  entry_count;
		logic [SUM_W-1:0]  probe_total;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV_HOME,
		ST_DIV_STEP,
		ST_DIV_WRAP,
		ST_PROBE_RD,
		ST_PROBE_CHK,
		ST_EVAL
	} dhte_state_t;

endpackage
`default_nettype wire

// File: src/dhte_ram.sv
`default_nettype none
module dhte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: src/double_hash_table_engine_top.sv
// walk from transfer in to result valid: an unused op code goes straight to evaluation, otherwise
//   remainder steps for home slot, probe step and step mod size, then a read and a check per probed
//   slot, then evaluation, with one more read state when the walk visits every slot
// throughput: one item at a time; next transfer in the cycle after the result is registered,
//   also while a stalled result holds the output register, which only holds up the next evaluation
// reset: clearing of all CAPACITY slots follows reset, with in_stall held high
`default_nettype none
module double_hash_table_engine_top
	import dhte_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_item_t        out_data,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int IW = $clog2(CAPACITY);
	localparam int NW = $clog2(CAPACITY + 1);
	localparam int PW = $clog2(CAPACITY + 2);
	localparam int WW = 2 + KEY_W + VALUE_BITS;
	localparam int RW = 17;

	dhte_state_t state_q, state_d;

	logic [TSIZE_W-1:0]    tsize_q;
	logic [DIV_W-1:0]      div_q;
	logic [NW-1:0]         eff_n;
	logic [DIV_W-1:0]      eff_d;

	logic [1:0]            op_q;
	logic [KEY_W-1:0]      key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [VALUE_BITS-1:0] hitval_q;
	logic [IW-1:0]         home_q, stm_q, idx_q, target_q, clr_q;
	logic [PW-1:0]         p_q;
	logic                  have_q, found_q;
	logic [NW-1:0]         count_q;
	logic [SUM_W-1:0]      psum_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	// remainder unit
	logic [KEY_W-1:0]      dvd_q;
	logic [RW-1:0]         rem_q, divisor, rem_nx;
	logic [RW:0]           rem_sh;
	logic [4:0]            cnt_q;
	logic                  div_last;
	logic [DIV_W-1:0]      step_w;

	// memory
	logic                  ram_we;
	logic [IW-1:0]         ram_waddr;
	logic [WW-1:0]         ram_wdata, ram_rdata;
	logic [1:0]            rd_st;
	logic [KEY_W-1:0]      rd_key;
	logic [VALUE_BITS-1:0] rd_val;

	// evaluation
	logic [IW:0]           adv_sum;
	logic [IW-1:0]         adv_idx;
	logic                  out_free, accept, ins_ok, del_ok, find_op;
	logic [NW-1:0]         count_nx;
	logic [SUM_W:0]        psum_add;
	logic [SUM_W-1:0]      psum_nx;
	logic [63:0]           in_val64, hit64;
	out_item_t             res;

	// effective configuration
	always_comb begin
		if (tsize_q == '0) begin
			eff_n = NW'(1);
		end else if (32'(tsize_q) > CAPACITY) begin
			eff_n = NW'(CAPACITY);
		end else begin
			eff_n = NW'(tsize_q);
		end
		eff_d = (div_q == '0) ? DIV_W'(1) : div_q;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q <= TSIZE_RESET;
			div_q   <= DIV_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TABLE_SIZE:   tsize_q <= cfg_data[TSIZE_W-1:0];
				CFG_STEP_DIVISOR: div_q   <= cfg_data[DIV_W-1:0];
				default:          ;
			endcase
		end
	end

	// one restoring remainder step per cycle
	assign divisor  = (state_q == ST_DIV_STEP) ? RW'(eff_d) : RW'(eff_n);
	assign rem_sh   = {rem_q, dvd_q[KEY_W-1]};
	assign rem_nx   = (rem_sh >= {1'b0, divisor}) ? RW'(rem_sh - {1'b0, divisor}) : RW'(rem_sh);
	assign div_last = (cnt_q == 5'(KEY_W - 1));
	assign step_w   = eff_d - rem_nx[DIV_W-1:0];

	// slot memory
	dhte_ram #(
		.WIDTH(WW),
		.DEPTH(CAPACITY)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign rd_st  = ram_rdata[WW-1 -: 2];
	assign rd_key = ram_rdata[VALUE_BITS +: KEY_W];
	assign rd_val = ram_rdata[VALUE_BITS-1:0];

	// next probe slot, wrapped once
	always_comb begin
		adv_sum = (IW+1)'(idx_q) + (IW+1)'(stm_q);
		if (adv_sum >= (IW+1)'(eff_n)) begin
			adv_sum = adv_sum - (IW+1)'(eff_n);
		end
		adv_idx = adv_sum[IW-1:0];
	end

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_val64 = 64'(in_data.value);
	assign hit64    = 64'(hitval_q);

	// result of the finished walk
	always_comb begin
		ins_ok   = (op_q == OP_INSERT) && have_q && !found_q;
		del_ok   = (op_q == OP_ERASE) && found_q;
		find_op  = (op_q == OP_FIND);
		count_nx = count_q;
		if (ins_ok) begin
			count_nx = count_q + NW'(1);
		end else if (del_ok && count_q != '0) begin
			count_nx = count_q - NW'(1);
		end
		psum_add = {1'b0, psum_q} + (SUM_W+1)'(p_q);
		psum_nx  = psum_q;
		if (find_op) begin
			psum_nx = psum_add[SUM_W] ? SUM_MAX : psum_add[SUM_W-1:0];
		end
		res.status      = !(ins_ok || ((op_q == OP_ERASE || find_op) && found_q));
		res.home_slot   = (op_q == OP_INSERT) ? SLOT_W'(home_q) : '0;
		res.stored_slot = ins_ok ? SLOT_W'(target_q) : '0;
		res.found_value = ((op_q == OP_ERASE || find_op) && found_q) ? hit64[VAL_W-1:0] : '0;
		res.entry_count = CNT_W'(count_nx);
		res.probe_total = psum_nx;
	end

	// next state and memory writes
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (clr_q == IW'(CAPACITY - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (in_data.op == OP_INSERT || in_data.op == OP_ERASE ||
							in_data.op == OP_FIND) begin
						state_d = ST_DIV_HOME;
					end else begin
						state_d = ST_EVAL;
					end
				end
			end
			ST_DIV_HOME: if (div_last) state_d = ST_DIV_STEP;
			ST_DIV_STEP: if (div_last) state_d = ST_DIV_WRAP;
			ST_DIV_WRAP: if (div_last) state_d = ST_PROBE_RD;
			ST_PROBE_RD: begin
				state_d = (p_q > PW'(eff_n)) ? ST_EVAL : ST_PROBE_CHK;
			end
			ST_PROBE_CHK: begin
				if (rd_st == SLOT_EMPTY || (rd_st == SLOT_OCC && rd_key == key_q)) begin
					state_d = ST_EVAL;
				end else begin
					state_d = ST_PROBE_RD;
				end
			end
			ST_EVAL: begin
				if (out_free) begin
					state_d = ST_IDLE;
					if (ins_ok) begin
						ram_we    = 1'b1;
						ram_waddr = target_q;
						ram_wdata = {SLOT_OCC, key_q, val_q};
					end else if (del_ok) begin
						ram_we    = 1'b1;
						ram_waddr = idx_q;
						ram_wdata = {SLOT_TOMB, key_q, hitval_q};
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			count_q     <= '0;
			psum_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) clr_q <= clr_q + IW'(1);
			if (state_q == ST_EVAL && out_free) begin
				count_q     <= count_nx;
				psum_q      <= psum_nx;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and walk registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q    <= in_data.op;
				key_q   <= in_data.key;
				val_q   <= in_val64[VALUE_BITS-1:0];
				dvd_q   <= in_data.key;
				rem_q   <= '0;
				cnt_q   <= '0;
				have_q  <= 1'b0;
				found_q <= 1'b0;
				p_q     <= PW'(1);
			end
			ST_DIV_HOME, ST_DIV_STEP, ST_DIV_WRAP: begin
				if (div_last) begin
					rem_q <= '0;
					cnt_q <= '0;
					if (state_q == ST_DIV_HOME) begin
						home_q <= IW'(rem_nx);
						dvd_q  <= key_q;
					end else if (state_q == ST_DIV_STEP) begin
						dvd_q <= KEY_W'(step_w);
					end else begin
						stm_q <= IW'(rem_nx);
						idx_q <= home_q;
					end
				end else begin
					dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
					rem_q <= rem_nx;
					cnt_q <= cnt_q + 5'd1;
				end
			end
			ST_PROBE_CHK: begin
				if (rd_st == SLOT_EMPTY) begin
					if (!have_q) begin
						have_q   <= 1'b1;
						target_q <= idx_q;
					end
				end else if (rd_st == SLOT_OCC && rd_key == key_q) begin
					found_q  <= 1'b1;
					hitval_q <= rd_val;
				end else begin
					if (rd_st == SLOT_TOMB && !have_q) begin
						have_q   <= 1'b1;
						target_q <= idx_q;
					end
					idx_q <= adv_idx;
					p_q   <= p_q + PW'(1);
				end
			end
			ST_EVAL: if (out_free) out_q <= res;
			default: ;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall) else $error("item accepted without going busy");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= CAPACITY) else $error("entry count beyond capacity");
	a_idx_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE_CHK) |-> (NW'(idx_q) < eff_n)) else $error("probe slot outside table");
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE_RD) |-> (p_q <= PW'(eff_n) + PW'(1))) else $error("probe count runaway");
	a_result_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EVAL)) else $error("result without evaluation");

endmodule
`default_nettype wire
